// ===== hw/rtl/crc8p_pkg.sv =====
// shared constants, types and helper functions for the crc-8 packet receiver
`default_nettype none

package crc8p_pkg;

   // framing and crc constants
   localparam logic [7:0] START_BYTE = 8'hAA;
   localparam logic [7:0] CRC_POLY   = 8'h07;

   // event codes carried in the first body byte
   localparam logic [7:0] EV_DISPLAY   = 8'h01;
   localparam logic [7:0] EV_SERVO     = 8'h02;
   localparam logic [7:0] EV_LP_STATUS = 8'h04;
   localparam logic [7:0] EV_PARK_FULL = 8'h05;

   // servo scaling: pulse = base + angle * 100 / 180, 100/180 reduced to 5/9
   localparam logic [7:0] ANGLE_MAX  = 8'd180;
   localparam logic [7:0] ANGLE_OPEN = 8'd90;
   localparam logic [7:0] PULSE_BASE = 8'd50;
   localparam int PULSE_NUM   = 5;
   localparam int PULSE_DEN   = 9;
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP       = (2 ** RECIP_SHIFT + PULSE_DEN - 1) / PULSE_DEN;

   // flag value that selects the alternate meaning of the data byte
   localparam logic [7:0] DATA_ONE = 8'd1;

   // receive phase
   typedef enum logic [1:0] {
      PH_HUNT,
      PH_LEN,
      PH_BODY
   } phase_type;

   // decoded action
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_MESSAGE,
      ACT_SERVO,
      ACT_LOT_FULL,
      ACT_SPACES
   } action_type;

   // one finished packet result
   typedef struct packed {
      logic       crc_good;
      logic [7:0] event_code;
      logic [7:0] first_data;
      action_type action;
      logic [7:0] servo_pulse;
   } result_type;

   // crc-8 over one byte, msb first
   function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   // clamp the angle and scale it into timer ticks; /9 by reciprocal multiply
   function automatic logic [7:0] pulse_of(input logic [7:0] angle);
      logic [7:0]  a;
      logic [9:0]  scaled;
      logic [22:0] prod;
      a      = (angle > ANGLE_MAX) ? ANGLE_MAX : angle;
      scaled = 10'(a) * 10'(PULSE_NUM);
      prod   = 23'(scaled) * 23'(RECIP);
      return 8'(prod[22:RECIP_SHIFT]) + PULSE_BASE;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/crc8p_decode.sv =====
// action decode for a finished packet: crc check result, event and data to action
`default_nettype none

module crc8p_decode (
   input  wire logic                 crc_good,
   input  wire logic [7:0]           event_code,
   input  wire logic [7:0]           first_data,
   output crc8p_pkg::result_type     result
);

   crc8p_pkg::action_type act;
   logic [7:0]            pulse;

   // event table, only honored with a good crc
   always_comb begin
      act   = crc8p_pkg::ACT_NONE;
      pulse = 8'd0;
      if (crc_good) begin
         case (event_code)
            crc8p_pkg::EV_DISPLAY: begin
               act = crc8p_pkg::ACT_MESSAGE;
            end
            crc8p_pkg::EV_SERVO: begin
               act   = crc8p_pkg::ACT_SERVO;
               pulse = crc8p_pkg::pulse_of(first_data);
            end
            crc8p_pkg::EV_LP_STATUS: begin
               act   = crc8p_pkg::ACT_SERVO;
               pulse = crc8p_pkg::pulse_of((first_data == crc8p_pkg::DATA_ONE) ?
                                           crc8p_pkg::ANGLE_OPEN : 8'd0);
            end
            crc8p_pkg::EV_PARK_FULL: begin
               act = (first_data == crc8p_pkg::DATA_ONE) ? crc8p_pkg::ACT_LOT_FULL :
                                                          crc8p_pkg::ACT_SPACES;
            end
            default: begin
               act = crc8p_pkg::ACT_NONE;
            end
         endcase
      end
   end

   // pack the result
   always_comb begin
      result.crc_good    = crc_good;
      result.event_code  = event_code;
      result.first_data  = first_data;
      result.action      = act;
      result.servo_pulse = pulse;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/crc8_packet_receiver.sv =====
// top level of the crc-8 framed packet receiver
// Takes one received byte per beat and hunts for the 0xAA start byte, then a length
// byte L, L body bytes (event code, then data) and a crc byte; a crc-8 (poly 0x07,
// init 0) runs over the body. On the crc byte one result beat is given: crc status,
// event code, first data byte (0 if absent), decoded action and servo pulse. Bodies
// are not stored, so any L from 0 to 255 works. Each byte is registered at the input,
// parsed into the result register, so a byte can be taken every cycle unless a
// result is stalled at the output; in that case the input register holds. A crc byte
// goes through the input register and the result register to its result beat.
`default_nettype none

module crc8_packet_receiver (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_rx_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_crc_good,
   output logic [7:0]      rsp_event_code,
   output logic [7:0]      rsp_first_data,
   output logic [2:0]      rsp_action,
   output logic [7:0]      rsp_servo_pulse
);

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;

   // parser state
   crc8p_pkg::phase_type phase_ff, phase_in;
   logic [7:0] length_ff, length_in;
   logic [8:0] count_ff, count_in;
   logic [7:0] crc_ff, crc_in;
   logic [7:0] event_ff, event_in;
   logic [7:0] data_ff, data_in;

   // result register
   logic                  out_valid_ff, out_valid_in;
   crc8p_pkg::result_type out_ff;
   crc8p_pkg::result_type result;

   logic req_accept;
   logic advance;
   logic work;
   logic in_body;
   logic emit;

   // handshake
   assign advance    = !(out_valid_ff && rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign work       = in_valid_ff && advance;
   assign in_body    = count_ff < {1'b0, length_ff};
   assign emit       = work && (phase_ff == crc8p_pkg::PH_BODY) && !in_body;

   // input stage
   always_comb begin
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_accept) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (work) begin
         case (phase_ff)
            crc8p_pkg::PH_LEN: begin
               phase_in = crc8p_pkg::PH_BODY;
            end
            crc8p_pkg::PH_BODY: begin
               phase_in = in_body ? crc8p_pkg::PH_BODY : crc8p_pkg::PH_HUNT;
            end
            default: begin
               phase_in = (in_byte_ff == crc8p_pkg::START_BYTE) ? crc8p_pkg::PH_LEN :
                                                                  crc8p_pkg::PH_HUNT;
            end
         endcase
      end
   end

   // length, count, crc and held bytes
   always_comb begin
      length_in = length_ff;
      count_in  = count_ff;
      crc_in    = crc_ff;
      event_in  = event_ff;
      data_in   = data_ff;
      if (work) begin
         case (phase_ff)
            crc8p_pkg::PH_LEN: begin
               length_in = in_byte_ff;
               count_in  = 9'd0;
               crc_in    = 8'd0;
               event_in  = 8'd0;
               data_in   = 8'd0;
            end
            crc8p_pkg::PH_BODY: begin
               if (in_body) begin
                  crc_in   = crc8p_pkg::crc8_next(crc_ff, in_byte_ff);
                  count_in = count_ff + 9'd1;
                  if (count_ff == 9'd0) begin
                     event_in = in_byte_ff;
                  end else if (count_ff == 9'd1) begin
                     data_in = in_byte_ff;
                  end
               end else begin
                  count_in = 9'd0;
               end
            end
            default: begin
               count_in = count_ff;
            end
         endcase
      end
   end

   crc8p_decode u_decode (
      .crc_good   (in_byte_ff == crc_ff),
      .event_code (event_ff),
      .first_data (data_ff),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= crc8p_pkg::PH_HUNT;
         length_ff <= 8'd0;
         count_ff  <= 9'd0;
         crc_ff    <= 8'd0;
         event_ff  <= 8'd0;
         data_ff   <= 8'd0;
      end else begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         count_ff  <= count_in;
         crc_ff    <= crc_in;
         event_ff  <= event_in;
         data_ff   <= data_in;
      end
   end

   // result register
   always_comb begin
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (emit) begin
         out_ff <= result;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_crc_good    = out_ff.crc_good;
   assign rsp_event_code  = out_ff.event_code;
   assign rsp_first_data  = out_ff.first_data;
   assign rsp_action      = out_ff.action;
   assign rsp_servo_pulse = out_ff.servo_pulse;

endmodule

`default_nettype wire

// ===== hw/rtl/crc8p_checker.sv =====
// port-level checks for the crc-8 packet receiver, bound to the top level
`default_nettype none

module crc8p_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic       rsp_crc_good,
   input wire logic [7:0] rsp_event_code,
   input wire logic [7:0] rsp_first_data,
   input wire logic [2:0] rsp_action,
   input wire logic [7:0] rsp_servo_pulse
);

   // a stalled result beat stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_crc_good) &&
         $stable(rsp_event_code) && $stable(rsp_first_data) &&
         $stable(rsp_action) && $stable(rsp_servo_pulse))
      else $error("result beat changed while stalled");

   // no result right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

   // a bad crc never triggers an action
   a_bad_crc: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_crc_good |->
         rsp_action == crc8p_pkg::ACT_NONE && rsp_servo_pulse == 8'd0)
      else $error("action on bad crc");

   // servo pulse in range for servo actions, zero otherwise
   a_pulse_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_action == crc8p_pkg::ACT_SERVO &&
          rsp_servo_pulse >= 8'd50 && rsp_servo_pulse <= 8'd150) ||
         (rsp_action != crc8p_pkg::ACT_SERVO && rsp_servo_pulse == 8'd0))
      else $error("servo pulse out of range");

endmodule

bind crc8_packet_receiver crc8p_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_crc_good    (rsp_crc_good),
   .rsp_event_code  (rsp_event_code),
   .rsp_first_data  (rsp_first_data),
   .rsp_action      (rsp_action),
   .rsp_servo_pulse (rsp_servo_pulse)
);

`default_nettype wire
